/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the digest checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SHA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sha1 assertion failed");

// expression must never be true outside reset
`define SHA_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("sha1 forbidden condition seen");

`endif

/* rtl/core/sha1_pkg.sv */
// ---------------------------------------------------------------------------
// SHA-1 package
// Constants, types and helpers shared by the digest core.
// ---------------------------------------------------------------------------
package sha1_pkg;

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [31:0] H_INIT0 = 32'h67452301;
   localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
   localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
   localparam logic [31:0] H_INIT3 = 32'h10325476;
   localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [6:0] LAST_ROUND     = 7'd79;
   localparam logic [6:0] RAW_ROUNDS     = 7'd16;
   localparam logic [5:0] LAST_BYTE_POS  = 6'd63;
   localparam logic [5:0] LENGTH_POS     = 6'd56;
   localparam logic [2:0] LAST_WORD      = 3'd4;

   typedef enum logic [1:0] {
      GRP_CHOOSE = 2'd0,
      GRP_PARITY = 2'd1,
      GRP_MAJORITY = 2'd2,
      GRP_PARITY2 = 2'd3
   } group_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } work_type;

   typedef struct packed {
      logic byte_en;
      logic word_en;
      logic raw;
   } sched_ctl_type;

   function automatic group_type round_group(input logic [6:0] rnd);
      group_type g;
      if (rnd < 7'd20) begin
         g = GRP_CHOOSE;
      end else if (rnd < 7'd40) begin
         g = GRP_PARITY;
      end else if (rnd < 7'd60) begin
         g = GRP_MAJORITY;
      end else begin
         g = GRP_PARITY2;
      end
      return g;
   endfunction

endpackage

/* rtl/core/sha1_sched.sv */
// ---------------------------------------------------------------------------
// SHA-1 block buffer and message schedule
// 512-bit shift line: gathers bytes, then supplies one schedule word a round.
// ---------------------------------------------------------------------------
module sha1_sched (
   input  logic                   clock,
   input  sha1_pkg::sched_ctl_type ctl,
   input  logic [7:0]             byte_data,
   output logic [31:0]            w
);
   import sha1_pkg::*;

   logic [511:0] line_ff;
   logic [511:0] line_in;
   logic [31:0]  mix;

   assign mix = line_ff[511:480] ^ line_ff[447:416] ^ line_ff[255:224] ^ line_ff[95:64];
   assign w   = ctl.raw ? line_ff[511:480] : {mix[30:0], mix[31]};

   always_comb begin
      line_in = line_ff;
      if (ctl.byte_en) begin
         line_in = {line_ff[503:0], byte_data};
      end else if (ctl.word_en) begin
         line_in = {line_ff[479:0], w};
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

endmodule

/* rtl/core/sha1_round.sv */
// ---------------------------------------------------------------------------
// SHA-1 round unit
// One compression round on the working registers, shared over all 80 rounds.
// ---------------------------------------------------------------------------
module sha1_round (
   input  sha1_pkg::work_type  cur,
   input  logic [31:0]         w,
   input  sha1_pkg::group_type grp,
   output sha1_pkg::work_type  nxt
);
   import sha1_pkg::*;

   logic [31:0] fval;
   logic [31:0] kval;
   logic [31:0] temp;

   always_comb begin
      case (grp)
         GRP_CHOOSE: begin
            fval = cur.d ^ (cur.b & (cur.c ^ cur.d));
            kval = K_ROUND0;
         end
         GRP_PARITY: begin
            fval = cur.b ^ cur.c ^ cur.d;
            kval = K_ROUND1;
         end
         GRP_MAJORITY: begin
            fval = (cur.b & cur.c) | (cur.d & (cur.b | cur.c));
            kval = K_ROUND2;
         end
         default: begin
            fval = cur.b ^ cur.c ^ cur.d;
            kval = K_ROUND3;
         end
      endcase
   end

   assign temp = {cur.a[26:0], cur.a[31:27]} + fval + cur.e + kval + w;

   assign nxt.a = temp;
   assign nxt.b = cur.a;
   assign nxt.c = {cur.b[1:0], cur.b[31:2]};
   assign nxt.d = cur.c;
   assign nxt.e = cur.d;

endmodule

/* rtl/core/sha1_message_digest.sv */
// ---------------------------------------------------------------------------
// SHA-1 message digest
// Byte-serial SHA-1: buffers 64-byte blocks, pads, emits five digest words.
// ---------------------------------------------------------------------------
//  channel  direction  payload                                   handshake
//  req      in         msg_byte, has_byte, end_of_message         valid/ready
//  rsp      out        digest_word, word_number, final_word       valid/ready
//
//  A data byte is taken while idle; the 64th byte of a block then runs the
//  rounds through the shared round unit, followed by one chaining add.
//  End of message: pad bytes to the block end, rounds and a chaining add
//  per padded block, five result items; req_ready is low throughout.
//  Reset is synchronous and restores the initial chaining words.
//  rsp stalls hold the current word; no input is taken until all five go.
// ---------------------------------------------------------------------------
module sha1_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_final_word
);
   import sha1_pkg::*;

   state_type     state_ff, state_in;
   logic [5:0]    pos_ff, pos_in;
   logic [60:0]   count_ff, count_in;
   logic [6:0]    round_ff, round_in;
   work_type      work_ff, work_in;
   logic [31:0]   chain_ff [5];
   logic [31:0]   chain_in [5];
   logic [2:0]    word_ff, word_in;
   logic          pad_ff, pad_in;
   logic          mark_ff, mark_in;
   logic          lenok_ff, lenok_in;
   logic          last_ff, last_in;

   sched_ctl_type sched_ctl;
   logic [7:0]    byte_data;
   logic [31:0]   w;
   work_type      round_nxt;
   work_type      chain_work;
   logic [63:0]   bit_len;
   logic [7:0]    len_byte;

   assign bit_len    = {count_ff, 3'b000};
   assign len_byte   = bit_len[{3'd7 - pos_ff[2:0], 3'b000} +: 8];
   assign chain_work = '{a: chain_ff[0], b: chain_ff[1], c: chain_ff[2],
                         d: chain_ff[3], e: chain_ff[4]};

   sha1_sched u_sched (
      .clock     (clock),
      .ctl       (sched_ctl),
      .byte_data (byte_data),
      .w         (w)
   );

   sha1_round u_round (
      .cur (work_ff),
      .w   (w),
      .grp (round_group(round_ff)),
      .nxt (round_nxt)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_ff[0];
   assign rsp_word_number = word_ff;
   assign rsp_final_word  = (word_ff == LAST_WORD);

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      round_in  = round_ff;
      work_in   = work_ff;
      chain_in  = chain_ff;
      word_in   = word_ff;
      pad_in    = pad_ff;
      mark_in   = mark_ff;
      lenok_in  = lenok_ff;
      last_in   = last_ff;
      sched_ctl = '{byte_en: 1'b0, word_en: 1'b0, raw: (round_ff < RAW_ROUNDS)};
      byte_data = req_msg_byte;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  sched_ctl.byte_en = 1'b1;
                  pos_in   = pos_ff + 6'd1;
                  count_in = count_ff + 61'd1;
               end
               if (req_has_byte && pos_ff == LAST_BYTE_POS) begin
                  state_in = ST_ROUND;
                  round_in = '0;
                  work_in  = chain_work;
                  pad_in   = req_end_of_message;
                  mark_in  = req_end_of_message;
                  lenok_in = 1'b0;
                  last_in  = 1'b0;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
                  pad_in   = 1'b1;
                  mark_in  = 1'b1;
                  lenok_in = 1'b0;
                  last_in  = 1'b0;
               end
            end
         end
         ST_PAD: begin
            sched_ctl.byte_en = 1'b1;
            if (mark_ff) begin
               byte_data = PAD_MARK;
            end else if (pos_ff >= LENGTH_POS && lenok_ff) begin
               byte_data = len_byte;
            end else begin
               byte_data = 8'h00;
            end
            pos_in  = pos_ff + 6'd1;
            mark_in = 1'b0;
            if (mark_ff) begin
               lenok_in = (pos_ff < LENGTH_POS);
            end
            if (pos_ff == LAST_BYTE_POS) begin
               state_in = ST_ROUND;
               round_in = '0;
               work_in  = chain_work;
               last_in  = !mark_ff && lenok_ff;
               lenok_in = 1'b1;
            end
         end
         ST_ROUND: begin
            sched_ctl.word_en = 1'b1;
            work_in  = round_nxt;
            round_in = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in[0] = chain_ff[0] + work_ff.a;
            chain_in[1] = chain_ff[1] + work_ff.b;
            chain_in[2] = chain_ff[2] + work_ff.c;
            chain_in[3] = chain_ff[3] + work_ff.d;
            chain_in[4] = chain_ff[4] + work_ff.e;
            if (last_ff) begin
               state_in = ST_OUT;
               word_in  = '0;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               chain_in[0] = chain_ff[1];
               chain_in[1] = chain_ff[2];
               chain_in[2] = chain_ff[3];
               chain_in[3] = chain_ff[4];
               chain_in[4] = chain_ff[0];
               word_in     = word_ff + 3'd1;
               if (word_ff == LAST_WORD) begin
                  state_in    = ST_IDLE;
                  chain_in[0] = H_INIT0;
                  chain_in[1] = H_INIT1;
                  chain_in[2] = H_INIT2;
                  chain_in[3] = H_INIT3;
                  chain_in[4] = H_INIT4;
                  count_in    = '0;
                  pos_in      = '0;
                  pad_in      = 1'b0;
                  mark_in     = 1'b0;
                  lenok_in    = 1'b0;
                  last_in     = 1'b0;
                  word_in     = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pos_ff      <= '0;
         count_ff    <= '0;
         round_ff    <= '0;
         word_ff     <= '0;
         pad_ff      <= 1'b0;
         mark_ff     <= 1'b0;
         lenok_ff    <= 1'b0;
         last_ff     <= 1'b0;
         chain_ff[0] <= H_INIT0;
         chain_ff[1] <= H_INIT1;
         chain_ff[2] <= H_INIT2;
         chain_ff[3] <= H_INIT3;
         chain_ff[4] <= H_INIT4;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
         round_ff <= round_in;
         word_ff  <= word_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         lenok_ff <= lenok_in;
         last_ff  <= last_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

endmodule

/* rtl/core/sha1_checker.sv */
// ---------------------------------------------------------------------------
// SHA-1 port checker
// Watches the digest core's ports and checks result ordering and handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_number,
   input logic        rsp_final_word
);
   import sha1_pkg::*;

   logic        word_is_last;
   logic        word_step;
   logic        rsp_wait;
   logic [34:0] rsp_payload;
   logic [2:0]  seq_num_ff;

   assign word_is_last = (rsp_word_number == LAST_WORD);
   assign word_step    = rsp_valid && rsp_ready && !rsp_final_word;
   assign rsp_wait     = rsp_valid && !rsp_ready;
   assign rsp_payload  = {rsp_digest_word, rsp_word_number};

   always_ff @(posedge clock) begin
      seq_num_ff <= rsp_word_number + 3'd1;
   end

   `SHA_ASSERT(a_final_tag, clock, reset, rsp_valid |-> (rsp_final_word == word_is_last))
   `SHA_ASSERT(a_word_seq, clock, reset, word_step |=> (rsp_valid && rsp_word_number == seq_num_ff))
   `SHA_NEVER(a_busy_out, clock, reset, req_ready && rsp_valid)
   `SHA_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> (rsp_valid && $stable(rsp_payload)))

endmodule

bind sha1_message_digest sha1_checker u_sha1_checker (.*);
